/* sv/fpac_pkg.sv */
// shared types, constants and status codes of the frame parser with additive checksum
package fpac_pkg;

	// header bytes and the sum of the full header
	localparam logic [7:0] HDR_A   = 8'hAA;
	localparam logic [7:0] HDR_B   = 8'h29;
	localparam logic [7:0] HDR_SUM = 8'(HDR_A + HDR_A + HDR_B);

	// reset value of the length limit
	localparam logic [7:0] MAX_LEN_RESET = 8'd255;

	// payload byte positions that are captured
	localparam logic [7:0] IDX_STATUS = 8'd0;
	localparam logic [7:0] IDX_TGT_LO = 8'd1;
	localparam logic [7:0] IDX_TGT_HI = 8'd2;
	localparam logic [7:0] IDX_LAT_0  = 8'd3;
	localparam logic [7:0] IDX_LAT_1  = 8'd4;
	localparam logic [7:0] IDX_LAT_2  = 8'd5;
	localparam logic [7:0] IDX_LAT_3  = 8'd6;

	// frame status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CSUM    = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;

	// parse phases
	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_HUNT3,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	// one result word
	typedef struct packed {
		logic [1:0]         frame_status;
		logic [7:0]         payload_length;
		logic [7:0]         state_value;
		logic signed [15:0] target_id;
		logic signed [31:0] latitude_micro;
		logic [7:0]         received_checksum;
		logic [7:0]         computed_checksum;
	} result_t;

endpackage

/* sv/fpac_in_reg.sv */
// input register stage holding one received byte
module fpac_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       adv,
	output logic       step,
	output logic [7:0] byte_s1
);
	import fpac_pkg::*;

	logic valid_s1;

	// the held word moves on when the result side can take it
	assign step     = valid_s1 & adv;
	assign in_stall = valid_s1 & ~adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* sv/fpac_parser.sv */
// frame parse state machine, checksum and field capture
module fpac_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_s1,
	input  logic [7:0]        max_len,
	output logic              res_valid,
	output fpac_pkg::result_t res
);
	import fpac_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  stat_q, stat_d;
	logic [15:0] tgt_q, tgt_d;
	logic [31:0] lat_q, lat_d;
	logic        len_bad;
	logic [7:0]  idx_inc;
	logic [7:0]  sum_add;

	assign len_bad = (byte_s1 == 8'd0) || (byte_s1 > max_len);
	assign idx_inc = idx_q + 8'd1;
	assign sum_add = sum_q + byte_s1;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT1: phase_d = (byte_s1 == HDR_A) ? PH_HUNT2 : PH_HUNT1;
			PH_HUNT2: phase_d = (byte_s1 == HDR_A) ? PH_HUNT3 : PH_HUNT1;
			PH_HUNT3: begin
				priority if (byte_s1 == HDR_B) phase_d = PH_LENGTH;
				else if (byte_s1 == HDR_A)     phase_d = PH_HUNT3;
				else                           phase_d = PH_HUNT1;
			end
			PH_LENGTH:  phase_d = len_bad ? PH_HUNT1 : PH_PAYLOAD;
			PH_PAYLOAD: phase_d = (idx_inc >= len_q) ? PH_CHECK : PH_PAYLOAD;
			PH_CHECK:   phase_d = PH_HUNT1;
			default:    phase_d = PH_HUNT1;
		endcase
	end

	// datapath updates and result
	always_comb begin
		idx_d     = idx_q;
		len_d     = len_q;
		sum_d     = sum_q;
		stat_d    = stat_q;
		tgt_d     = tgt_q;
		lat_d     = lat_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_HUNT3: begin
				if (byte_s1 == HDR_B) begin
					sum_d = HDR_SUM;
				end
			end
			PH_LENGTH: begin
				if (len_bad) begin
					res_valid          = 1'b1;
					res.frame_status   = ST_BAD_LEN;
					res.payload_length = byte_s1;
				end else begin
					len_d  = byte_s1;
					idx_d  = 8'd0;
					sum_d  = sum_add;
					stat_d = 8'd0;
					tgt_d  = 16'd0;
					lat_d  = 32'd0;
				end
			end
			PH_PAYLOAD: begin
				sum_d = sum_add;
				idx_d = idx_inc;
				unique case (idx_q)
					IDX_STATUS: stat_d        = byte_s1;
					IDX_TGT_LO: tgt_d[7:0]    = byte_s1;
					IDX_TGT_HI: tgt_d[15:8]   = byte_s1;
					IDX_LAT_0:  lat_d[7:0]    = byte_s1;
					IDX_LAT_1:  lat_d[15:8]   = byte_s1;
					IDX_LAT_2:  lat_d[23:16]  = byte_s1;
					IDX_LAT_3:  lat_d[31:24]  = byte_s1;
					default: ;
				endcase
			end
			PH_CHECK: begin
				res_valid             = 1'b1;
				res.frame_status      = (byte_s1 == sum_q) ? ST_OK : ST_CSUM;
				res.payload_length    = len_q;
				res.state_value       = stat_q;
				res.target_id         = tgt_q;
				res.latitude_micro    = lat_q;
				res.received_checksum = byte_s1;
				res.computed_checksum = sum_q;
			end
			default: ;
		endcase
		res_valid = res_valid & step;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			idx_q   <= 8'd0;
			len_q   <= 8'd0;
			sum_q   <= 8'd0;
			stat_q  <= 8'd0;
			tgt_q   <= 16'd0;
			lat_q   <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			stat_q  <= stat_d;
			tgt_q   <= tgt_d;
			lat_q   <= lat_d;
		end
	end

endmodule

/* sv/fpac_out_reg.sv */
// result register towards the output channel
module fpac_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  fpac_pkg::result_t res,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_stall,
	output fpac_pkg::result_t out_res
);
	import fpac_pkg::*;

	logic valid_q;

	// free when empty or being taken this cycle
	assign adv       = ~valid_q | ~out_stall;
	assign out_valid = valid_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res_valid;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_res <= res;
		end
	end

endmodule

/* sv/frame_parser_additive_checksum_unit.sv */
// top level of the byte-serial frame parser with additive checksum
// the last byte of a result sits in the input register, the result in the output register
// throughput: one byte per cycle, limited only by stall on the output channel
// a result word waits in the output register while the next byte is taken
// reset: asynchronous, clears the hunt state, captures and output valid; limit returns to 255
module frame_parser_additive_checksum_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         frame_status,
	output logic [7:0]         payload_length,
	output logic [7:0]         state_value,
	output logic signed [15:0] target_id,
	output logic signed [31:0] latitude_micro,
	output logic [7:0]         received_checksum,
	output logic [7:0]         computed_checksum
);
	import fpac_pkg::*;

	logic       adv;
	logic       step;
	logic [7:0] byte_s1;
	logic [7:0] max_len_q;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// length limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	fpac_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.adv      (adv),
		.step     (step),
		.byte_s1  (byte_s1)
	);

	fpac_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	fpac_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// result fields
	assign frame_status      = out_res.frame_status;
	assign payload_length    = out_res.payload_length;
	assign state_value       = out_res.state_value;
	assign target_id         = out_res.target_id;
	assign latitude_micro    = out_res.latitude_micro;
	assign received_checksum = out_res.received_checksum;
	assign computed_checksum = out_res.computed_checksum;

	// a good frame carries matching checksums
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status == ST_OK) |-> (received_checksum == computed_checksum))
		else $error("ok frame with differing checksums");

	// a bad length word carries zero checksums and a zero state value
	a_bad_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status == ST_BAD_LEN) |->
			(received_checksum == 8'd0 && computed_checksum == 8'd0 && state_value == 8'd0))
		else $error("bad length word with non-zero fields");

	// status stays within its codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == ST_OK || frame_status == ST_CSUM ||
			frame_status == ST_BAD_LEN))
		else $error("undefined frame status");

	// input stalls only while the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

endmodule

/* sim/frame_parser_additive_checksum_unit_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench of the byte-serial frame parser with additive checksum
module frame_parser_additive_checksum_unit_tb;
	import fpac_pkg::*;

	typedef logic [7:0] byte_list_t[$];

	localparam int RANDOM_BYTES  = 950;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_GUARD   = 50000;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte   = 8'h00;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_data  = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         frame_status;
	logic [7:0]         payload_length;
	logic [7:0]         state_value;
	logic signed [15:0] target_id;
	logic signed [31:0] latitude_micro;
	logic [7:0]         received_checksum;
	logic [7:0]         computed_checksum;

	frame_parser_additive_checksum_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.frame_status      (frame_status),
		.payload_length    (payload_length),
		.state_value       (state_value),
		.target_id         (target_id),
		.latitude_micro    (latitude_micro),
		.received_checksum (received_checksum),
		.computed_checksum (computed_checksum)
	);

	// byte source and frame bookkeeping
	logic [7:0] tx_bytes[$];
	result_t    awaited_frames[$];
	result_t    want_frame;
	int         bytes_queued = 0;
	int         bytes_taken  = 0;
	int         error_count  = 0;
	int         tx_wait      = 0;
	int         rx_wait      = 0;
	bit         tx_idle      = 1'b0;
	bit         rx_idle      = 1'b0;
	logic       rx_hold      = 1'b0;
	event       hold_off_start;

	// parser state as predicted
	logic [7:0]  len_limit    = MAX_LEN_RESET;
	phase_t      hunt_phase   = PH_HUNT1;
	logic [7:0]  body_index   = 8'h00;
	logic [7:0]  body_length  = 8'h00;
	logic [7:0]  frame_sum    = 8'h00;
	logic [7:0]  cap_status   = 8'h00;
	logic [15:0] cap_target   = 16'h0000;
	logic [31:0] cap_latitude = 32'h0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// payload bytes lean towards header values to tempt false header matches
	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return HDR_A;
		if (r < 17)
			return HDR_B;
		return 8'($urandom);
	endfunction

	// one received byte through the predicted parser; a finished frame joins the queue
	task automatic parse_byte(input logic [7:0] b);
		result_t frame;
		frame = '0;
		case (hunt_phase)
			PH_HUNT2: begin
				hunt_phase = (b == HDR_A) ? PH_HUNT3 : PH_HUNT1;
			end
			PH_HUNT3: begin
				if (b == HDR_B) begin
					hunt_phase = PH_LENGTH;
					frame_sum  = HDR_SUM;
				end else if (b != HDR_A) begin
					hunt_phase = PH_HUNT1;
				end
			end
			PH_LENGTH: begin
				if (b == 8'd0 || b > len_limit) begin
					frame.frame_status   = ST_BAD_LEN;
					frame.payload_length = b;
					awaited_frames.push_back(frame);
					hunt_phase = PH_HUNT1;
				end else begin
					body_length  = b;
					body_index   = 8'h00;
					frame_sum    = frame_sum + b;
					cap_status   = 8'h00;
					cap_target   = 16'h0000;
					cap_latitude = 32'h0;
					hunt_phase   = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				frame_sum = frame_sum + b;
				case (body_index)
					IDX_STATUS: cap_status          = b;
					IDX_TGT_LO: cap_target[7:0]     = b;
					IDX_TGT_HI: cap_target[15:8]    = b;
					IDX_LAT_0:  cap_latitude[7:0]   = b;
					IDX_LAT_1:  cap_latitude[15:8]  = b;
					IDX_LAT_2:  cap_latitude[23:16] = b;
					IDX_LAT_3:  cap_latitude[31:24] = b;
					default: ;
				endcase
				body_index = body_index + 8'd1;
				if (body_index >= body_length)
					hunt_phase = PH_CHECK;
			end
			PH_CHECK: begin
				frame.frame_status      = (b == frame_sum) ? ST_OK : ST_CSUM;
				frame.payload_length    = body_length;
				frame.state_value       = cap_status;
				frame.target_id         = cap_target;
				frame.latitude_micro    = cap_latitude;
				frame.received_checksum = b;
				frame.computed_checksum = frame_sum;
				awaited_frames.push_back(frame);
				hunt_phase = PH_HUNT1;
			end
			default: begin
				hunt_phase = (b == HDR_A) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endtask

	// header with optional extra leading AA bytes
	task automatic queue_header(input int extra_aa);
		repeat (extra_aa + 2) queue_byte(HDR_A);
		queue_byte(HDR_B);
	endtask

	// length byte, then payload and checksum when the length passes the limit
	task automatic queue_body(input logic [7:0] len, input byte_list_t given,
			input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		sum = HDR_SUM + len;
		queue_byte(len);
		if (len != 8'd0 && len <= len_limit) begin
			for (int i = 0; i < len; i++) begin
				b   = (i < given.size()) ? given[i] : payload_byte();
				sum = sum + b;
				queue_byte(b);
			end
			queue_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
		end
	endtask

	// sender stops until every word is taken and every frame is out
	task automatic wait_idle();
		int guard;
		guard = 0;
		while ((bytes_taken != bytes_queued || awaited_frames.size() != 0)
				&& guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		// trailing bytes that end no frame may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length_limit(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		len_limit = v;
	endtask

	// input driver: one byte word per accepted handshake, with random gaps while tx_idle is set
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_byte(rx_byte);
				bytes_taken++;
				tx_wait = tx_idle ? pick_gap() : 0;
			end
			if (!in_valid || !in_stall) begin
				if (tx_wait > 0) begin
					in_valid <= 1'b0;
					tx_wait--;
				end else if (tx_bytes.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte  <= tx_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			// compare each result word with the oldest frame pending
			if (out_valid && !out_stall) begin
				if (awaited_frames.size() == 0) begin
					flag_error("result word with no frame pending");
				end else begin
					want_frame = awaited_frames.pop_front();
					check_field("frame_status", 32'(frame_status),
						32'(want_frame.frame_status));
					check_field("payload_length", 32'(payload_length),
						32'(want_frame.payload_length));
					check_field("state_value", 32'(state_value),
						32'(want_frame.state_value));
					check_field("target_id", 32'(target_id),
						32'(want_frame.target_id));
					check_field("latitude_micro", latitude_micro,
						want_frame.latitude_micro);
					check_field("received_checksum", 32'(received_checksum),
						32'(want_frame.received_checksum));
					check_field("computed_checksum", 32'(computed_checksum),
						32'(want_frame.computed_checksum));
				end
			end
			if (rx_hold) begin
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
				if (rx_idle)
					rx_wait = pick_gap();
			end
		end
	end

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_off_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// stimulus phases
	initial begin
		byte_list_t none;
		byte_list_t low_ends;
		byte_list_t high_ends;
		int         stop_at;
		int         phase_end;
		int         pick;
		int         len_cap;
		logic [7:0] len;
		logic [7:0] new_limit;
		bit         carry_header;

		low_ends  = {8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h80};
		high_ends = {8'h00, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header breaks, overlapping header, field extremes, bad length, short frame with a corrupted checksum
		queue_byte(HDR_A);
		queue_byte(HDR_B);
		queue_byte(HDR_A);
		queue_byte(HDR_A);
		queue_byte(8'h55);
		queue_header(1);
		queue_body(8'd7, low_ends, 1'b0);
		queue_header(0);
		queue_body(8'd7, high_ends, 1'b0);
		queue_header(0);
		queue_body(8'd0, none, 1'b0);
		queue_header(0);
		queue_body(8'd2, none, 1'b1);
		wait_idle();

		// zero limit rejects every length; then the limit rises under a pending header
		set_length_limit(8'd0);
		queue_header(0);
		queue_body(8'd1, none, 1'b0);
		queue_header(0);
		queue_body(8'd255, none, 1'b0);
		queue_header(0);
		wait_idle();
		set_length_limit(8'd7);
		queue_body(8'd7, none, 1'b0);
		wait_idle();

		// smallest useful limit, then the largest frame at full limit
		set_length_limit(8'd1);
		queue_header(0);
		queue_body(8'd1, none, 1'b0);
		queue_header(0);
		queue_body(8'd2, none, 1'b0);
		wait_idle();
		set_length_limit(8'd255);
		queue_header(2);
		queue_body(8'd255, none, 1'b0);
		wait_idle();

		// receiver holds off while frames keep coming, so the parser backs up
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		-> hold_off_start;
		for (int i = 0; i < 40; i++) begin
			queue_header(0);
			queue_body(8'($urandom_range(0, 3)), none, i[0]);
		end
		wait_idle();

		// random phases, each under its own limit and idling mix
		stop_at      = bytes_queued + RANDOM_BYTES;
		carry_header = 1'b0;
		while (bytes_queued < stop_at) begin
			case ($urandom_range(0, 7))
				0: new_limit = 8'd255;
				1: new_limit = 8'd1;
				2: new_limit = 8'd0;
				3: new_limit = 8'd7;
				default: new_limit = 8'($urandom_range(2, 254));
			endcase
			set_length_limit(new_limit);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			// a header left by the previous phase meets its length under the new limit
			if (carry_header)
				queue_body(8'($urandom_range(0, 12)), none, 1'b0);
			phase_end = bytes_queued + $urandom_range(80, 200);
			while (bytes_queued < phase_end) begin
				len_cap = (len_limit == 8'd0) ? 255 : len_limit;
				pick = $urandom_range(0, 99);
				if (pick < 85)
					len = 8'($urandom_range(1, (len_cap < 10) ? len_cap : 10));
				else if (pick < 97)
					len = 8'($urandom_range(1, (len_cap < 40) ? len_cap : 40));
				else
					len = 8'($urandom_range(1, len_cap));
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					queue_header(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
					queue_body(len, none, $urandom_range(0, 3) == 0);
				end else if (pick < 80) begin
					// bad length: zero, or above the limit where there is room
					queue_header(0);
					if (len_limit == 8'hFF || pick < 74)
						queue_body(8'd0, none, 1'b0);
					else
						queue_body(8'($urandom_range(len_limit + 1, 255)), none, 1'b0);
				end else if (pick < 90) begin
					// header cut short by a byte that is neither header value
					repeat ($urandom_range(1, 3)) queue_byte(HDR_A);
					queue_byte(8'($urandom_range(0, 40)));
				end else begin
					repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
				end
			end
			carry_header = ($urandom_range(0, 2) == 0);
			if (carry_header)
				queue_header(0);
			wait_idle();
		end

		if (awaited_frames.size() != 0)
			flag_error($sformatf("%0d frames never came out", awaited_frames.size()));
		if (error_count == 0) begin
			$display("** frame_parser_additive_checksum_unit: PASSED **");
		end else begin
			$display("** frame_parser_additive_checksum_unit: FAILED **");
		end
		$finish;
	end

	// run limit
	initial begin
		#(5_000_000);
		$display("timeout with %0d of %0d bytes taken", bytes_taken, bytes_queued);
		$display("** frame_parser_additive_checksum_unit: FAILED **");
		$finish;
	end

endmodule
